// ----- design/aup_pkg.sv -----
package aup_pkg;

    localparam int CH_W            = 8;
    localparam int NUM_CH          = 3;
    localparam int DIVIDEND_W      = 2 * CH_W;
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_DIV_STAGES  = DIVIDEND_W / STEPS_PER_STAGE;

    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};
    localparam logic [CH_W-1:0] CH_MIN = '0;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [1:0] {
        MODE_DIV   = 2'd0,
        MODE_PASS  = 2'd1,
        MODE_WHITE = 2'd2
    } t_mode;

    // one divider lane: partial remainder, and dividend bits shifting out
    // while quotient bits shift in
    typedef struct packed {
        logic [CH_W-1:0]       rem;
        logic [DIVIDEND_W-1:0] nq;
    } t_lane;

    typedef struct packed {
        t_mode                        mode;
        logic [CH_W-1:0]              alpha;
        t_lane [NUM_CH-1:0]           lane;
        logic  [NUM_CH-1:0][CH_W-1:0] pass;
        logic                         wrapped;
        logic                         region_end;
    } t_div;

    function automatic t_lane div_steps(input t_lane l, input logic [CH_W-1:0] d);
        t_lane         r;
        logic [CH_W:0] t;
        logic [CH_W:0] diff;
        r = l;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            t    = {r.rem, r.nq[DIVIDEND_W-1]};
            diff = t - {1'b0, d};
            if (t >= {1'b0, d}) begin
                r.rem = diff[CH_W-1:0];
                r.nq  = {r.nq[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r.rem = t[CH_W-1:0];
                r.nq  = {r.nq[DIVIDEND_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ----- design/aup_div_stage.sv -----
module aup_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  aup_pkg::t_div i_data,
    input  logic          i_next_stall,
    output logic          o_valid,
    output aup_pkg::t_div o_data,
    output logic          o_stall
);
    import aup_pkg::*;

    logic r_valid;
    t_div r_data;
    t_div n_data;

    assign o_stall = r_valid && i_next_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        for (int c = 0; c < NUM_CH; c++) begin
            n_data.lane[c] = div_steps(i_data.lane[c], i_data.alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- design/argb_unpremultiply_pixel_top.sv -----
// Converts one premultiplied ARGB pixel per request into straight RGB,
// dropping alpha: channels pass through at alpha 255, become white at
// alpha 0, and otherwise are floor(255*c/alpha) kept to 8 bits, with
// o_wrapped set when a divided channel exceeds alpha. One pixel is taken
// every clock while o_stall is low. An entry register forms 255*c, four
// stages of a radix-2 restoring divider at 4 quotient bits each follow,
// then an output register. Each stage holds its request independently,
// so bubbles close up and a new pixel is taken while a result waits.
module argb_unpremultiply_pixel_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [aup_pkg::CH_W-1:0] i_alpha,
    input  logic [aup_pkg::CH_W-1:0] i_red_in,
    input  logic [aup_pkg::CH_W-1:0] i_green_in,
    input  logic [aup_pkg::CH_W-1:0] i_blue_in,
    input  logic                   i_region_end_in,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [aup_pkg::CH_W-1:0] o_red_out,
    output logic [aup_pkg::CH_W-1:0] o_green_out,
    output logic [aup_pkg::CH_W-1:0] o_blue_out,
    output logic                   o_wrapped,
    output logic                   o_region_end_out
);
    import aup_pkg::*;

    logic                       r_entry_valid;
    t_div                       r_entry;
    t_div                       n_entry;
    logic [NUM_CH-1:0][CH_W-1:0] w_ch;
    logic [NUM_CH-1:0]          w_above;

    logic                       w_valid [NUM_DIV_STAGES+1];
    t_div                       w_data  [NUM_DIV_STAGES+1];
    logic                       w_stall [NUM_DIV_STAGES+1];

    logic                       r_out_valid;
    logic [NUM_CH-1:0][CH_W-1:0] r_rgb;
    logic [NUM_CH-1:0][CH_W-1:0] n_rgb;
    logic                       r_wrapped;
    logic                       r_region_end;
    logic                       w_out_stall;

    assign w_ch[CH_RED]   = i_red_in;
    assign w_ch[CH_GREEN] = i_green_in;
    assign w_ch[CH_BLUE]  = i_blue_in;

    always_comb begin
        n_entry            = '0;
        n_entry.alpha      = i_alpha;
        n_entry.region_end = i_region_end_in;
        if (i_alpha == CH_MAX) begin
            n_entry.mode = MODE_PASS;
        end else if (i_alpha == CH_MIN) begin
            n_entry.mode = MODE_WHITE;
        end else begin
            n_entry.mode = MODE_DIV;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            w_above[c]          = w_ch[c] > i_alpha;
            n_entry.pass[c]     = w_ch[c];
            n_entry.lane[c].rem = '0;
            // 255*c = (c << 8) - c
            n_entry.lane[c].nq  = {w_ch[c], {CH_W{1'b0}}} - {{CH_W{1'b0}}, w_ch[c]};
        end
        n_entry.wrapped = (n_entry.mode == MODE_DIV) && (|w_above);
    end

    assign o_stall = r_entry_valid && w_stall[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= 1'b0;
        end else if (!o_stall) begin
            r_entry_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_entry <= n_entry;
        end
    end

    assign w_valid[0] = r_entry_valid;
    assign w_data[0]  = r_entry;

    for (genvar k = 0; k < NUM_DIV_STAGES; k++) begin : g_div
        aup_div_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (w_valid[k]),
            .i_data      (w_data[k]),
            .i_next_stall(w_stall[k+1]),
            .o_valid     (w_valid[k+1]),
            .o_data      (w_data[k+1]),
            .o_stall     (w_stall[k])
        );
    end

    assign w_out_stall                = r_out_valid && i_stall;
    assign w_stall[NUM_DIV_STAGES]    = w_out_stall;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            unique case (w_data[NUM_DIV_STAGES].mode)
                MODE_PASS:  n_rgb[c] = w_data[NUM_DIV_STAGES].pass[c];
                MODE_WHITE: n_rgb[c] = CH_MAX;
                MODE_DIV:   n_rgb[c] = w_data[NUM_DIV_STAGES].lane[c].nq[CH_W-1:0];
                default:    n_rgb[c] = w_data[NUM_DIV_STAGES].lane[c].nq[CH_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_out_stall) begin
            r_out_valid <= w_valid[NUM_DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_out_stall && w_valid[NUM_DIV_STAGES]) begin
            r_rgb        <= n_rgb;
            r_wrapped    <= w_data[NUM_DIV_STAGES].wrapped;
            r_region_end <= w_data[NUM_DIV_STAGES].region_end;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_red_out        = r_rgb[CH_RED];
    assign o_green_out      = r_rgb[CH_GREEN];
    assign o_blue_out       = r_rgb[CH_BLUE];
    assign o_wrapped        = r_wrapped;
    assign o_region_end_out = r_region_end;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NUM_DIV_STAGES] && w_data[NUM_DIV_STAGES].mode == MODE_DIV |->
            w_data[NUM_DIV_STAGES].lane[CH_RED].rem < w_data[NUM_DIV_STAGES].alpha &&
            w_data[NUM_DIV_STAGES].lane[CH_GREEN].rem < w_data[NUM_DIV_STAGES].alpha &&
            w_data[NUM_DIV_STAGES].lane[CH_BLUE].rem < w_data[NUM_DIV_STAGES].alpha)
        else $error("divider remainder not below alpha");

    a_div_mode_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NUM_DIV_STAGES] && w_data[NUM_DIV_STAGES].mode == MODE_DIV |->
            w_data[NUM_DIV_STAGES].alpha != CH_MIN && w_data[NUM_DIV_STAGES].alpha != CH_MAX)
        else $error("divide mode with opaque or transparent alpha");

    a_wrap_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NUM_DIV_STAGES] && w_data[NUM_DIV_STAGES].wrapped |->
            w_data[NUM_DIV_STAGES].mode == MODE_DIV)
        else $error("wrap flag outside divide mode");

    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall && o_valid)
        else $error("input stalled while output side free");
`endif

endmodule

// ----- tb/unpremultiply_checker.sv -----
module unpremultiply_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic                     i_req_stall,
    input  logic [aup_pkg::CH_W-1:0] i_alpha,
    input  logic [aup_pkg::CH_W-1:0] i_red,
    input  logic [aup_pkg::CH_W-1:0] i_green,
    input  logic [aup_pkg::CH_W-1:0] i_blue,
    input  logic                     i_region_end,
    input  logic                     i_res_valid,
    input  logic                     i_res_stall,
    input  logic [aup_pkg::CH_W-1:0] i_red_out,
    input  logic [aup_pkg::CH_W-1:0] i_green_out,
    input  logic [aup_pkg::CH_W-1:0] i_blue_out,
    input  logic                     i_wrapped,
    input  logic                     i_region_end_out,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked,
    output int                       o_wrapped_count,
    output int                       o_white_count,
    output int                       o_opaque_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import aup_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            wrapped;
        logic            region_end;
    } t_straight_px;

    t_straight_px straight_due[$];
    t_straight_px due_px;
    t_straight_px got_px;
    int           failures = 0;
    int           checked  = 0;
    int           wrapped  = 0;
    int           whites   = 0;
    int           opaques  = 0;

    function automatic logic [CH_W-1:0] scale_channel(input logic [CH_W-1:0] c,
                                                      input logic [CH_W-1:0] a);
        logic [2*CH_W-1:0] quotient;
        quotient = ((2*CH_W)'(c) * (2*CH_W)'(CH_MAX)) / (2*CH_W)'(a);
        return quotient[CH_W-1:0];
    endfunction

    function automatic t_straight_px unpremultiply(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] r,
                                                   input logic [CH_W-1:0] g,
                                                   input logic [CH_W-1:0] b,
                                                   input logic e);
        t_straight_px px;
        px.region_end = e;
        px.wrapped    = 1'b0;
        if (a == CH_MAX) begin
            px.red   = r;
            px.green = g;
            px.blue  = b;
        end else if (a == CH_MIN) begin
            px.red   = CH_MAX;
            px.green = CH_MAX;
            px.blue  = CH_MAX;
        end else begin
            px.red     = scale_channel(r, a);
            px.green   = scale_channel(g, a);
            px.blue    = scale_channel(b, a);
            px.wrapped = (r > a) || (g > a) || (b > a);
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) begin
                straight_due.insert(straight_due.size(),
                                    unpremultiply(i_alpha, i_red, i_green, i_blue,
                                                  i_region_end));
                if (i_alpha == CH_MIN) whites++;
                if (i_alpha == CH_MAX) opaques++;
            end
            if (i_res_valid && !i_res_stall) begin
                got_px = '{i_red_out, i_green_out, i_blue_out, i_wrapped, i_region_end_out};
                if (straight_due.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result r=%0d g=%0d b=%0d wrap=%0b end=%0b",
                                 got_px.red, got_px.green, got_px.blue,
                                 got_px.wrapped, got_px.region_end);
                end else begin
                    due_px = straight_due.pop_front();
                    checked++;
                    if (due_px.wrapped) wrapped++;
                    if (got_px.red !== due_px.red || got_px.green !== due_px.green ||
                        got_px.blue !== due_px.blue || got_px.wrapped !== due_px.wrapped ||
                        got_px.region_end !== due_px.region_end) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("mismatch: expected r=%0d g=%0d b=%0d wrap=%0b end=%0b",
                                     due_px.red, due_px.green, due_px.blue,
                                     due_px.wrapped, due_px.region_end);
                            $display("          got      r=%0d g=%0d b=%0d wrap=%0b end=%0b",
                                     got_px.red, got_px.green, got_px.blue,
                                     got_px.wrapped, got_px.region_end);
                        end
                    end
                end
            end
        end
        o_fail_count    <= failures;
        o_pending       <= straight_due.size();
        o_checked       <= checked;
        o_wrapped_count <= wrapped;
        o_white_count   <= whites;
        o_opaque_count  <= opaques;
    end

endmodule

// ----- tb/tb_argb_unpremultiply_pixel_top.sv -----
module tb_argb_unpremultiply_pixel_top;
    timeunit 1ns;
    timeprecision 1ps;
    import aup_pkg::*;

    logic            i_clk           = 1'b0;
    logic            i_rst_n         = 1'b0;
    logic            i_valid         = 1'b0;
    logic [CH_W-1:0] i_alpha         = '0;
    logic [CH_W-1:0] i_red_in        = '0;
    logic [CH_W-1:0] i_green_in      = '0;
    logic [CH_W-1:0] i_blue_in       = '0;
    logic            i_region_end_in = 1'b0;
    logic            i_stall         = 1'b0;
    logic            o_stall;
    logic            o_valid;
    logic [CH_W-1:0] o_red_out;
    logic [CH_W-1:0] o_green_out;
    logic [CH_W-1:0] o_blue_out;
    logic            o_wrapped;
    logic            o_region_end_out;

    int fail_count;
    int pending;
    int checked;
    int wrapped_count;
    int white_count;
    int opaque_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_tickets   = 0;
    int holds_done     = 0;
    int hold_left      = 0;

    argb_unpremultiply_pixel_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_alpha          (i_alpha),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .i_region_end_in  (i_region_end_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_red_out        (o_red_out),
        .o_green_out      (o_green_out),
        .o_blue_out       (o_blue_out),
        .o_wrapped        (o_wrapped),
        .o_region_end_out (o_region_end_out)
    );

    unpremultiply_checker check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_alpha          (i_alpha),
        .i_red            (i_red_in),
        .i_green          (i_green_in),
        .i_blue           (i_blue_in),
        .i_region_end     (i_region_end_in),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_red_out        (o_red_out),
        .i_green_out      (o_green_out),
        .i_blue_out       (o_blue_out),
        .i_wrapped        (o_wrapped),
        .i_region_end_out (o_region_end_out),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_wrapped_count  (wrapped_count),
        .o_white_count    (white_count),
        .o_opaque_count   (opaque_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_tickets != holds_done) begin
            holds_done = holds_done + 1;
            hold_left  = 99;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic offer_pixel(input logic [CH_W-1:0] a, input logic [CH_W-1:0] r,
                               input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                               input logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_alpha         <= a;
        i_red_in        <= r;
        i_green_in      <= g;
        i_blue_in       <= b;
        i_region_end_in <= e;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // mostly well-formed premultiplied pixels, some with channels above alpha
    task automatic offer_random_pixel();
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] ch [3];
        int              pick;
        pick = $urandom_range(99);
        if (pick < 8)       a = CH_MAX;
        else if (pick < 16) a = CH_MIN;
        else if (pick < 22) a = ($urandom_range(1) != 0) ? 8'd1 : 8'd254;
        else                a = CH_W'($urandom_range(255));
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(3) == 0) ch[i] = CH_W'($urandom_range(255));
            else                        ch[i] = CH_W'($urandom_range(a));
        end
        offer_pixel(a, ch[0], ch[1], ch[2], $urandom_range(15) == 0);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        #2_000_000;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opaque, transparent, channels above alpha, equal to alpha, extremes
        offer_pixel(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
        offer_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        offer_pixel(8'd255, 8'd18, 8'd200, 8'd97, 1'b0);
        offer_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        offer_pixel(8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
        offer_pixel(8'd0, 8'd33, 8'd170, 8'd5, 1'b0);
        offer_pixel(8'd1, 8'd0, 8'd1, 8'd0, 1'b0);
        offer_pixel(8'd1, 8'd2, 8'd0, 8'd0, 1'b0);
        offer_pixel(8'd1, 8'd255, 8'd255, 8'd255, 1'b1);
        offer_pixel(8'd254, 8'd254, 8'd253, 8'd0, 1'b0);
        offer_pixel(8'd254, 8'd0, 8'd255, 8'd1, 1'b0);
        offer_pixel(8'd128, 8'd128, 8'd127, 8'd129, 1'b0);
        offer_pixel(8'd128, 8'd64, 8'd1, 8'd0, 1'b1);
        offer_pixel(8'd16, 8'd15, 8'd16, 8'd17, 1'b0);
        offer_pixel(8'd3, 8'd1, 8'd2, 8'd3, 1'b0);
        offer_pixel(8'd200, 8'd201, 8'd199, 8'd255, 1'b1);
        offer_pixel(8'd85, 8'd170, 8'd42, 8'd85, 1'b0);
        offer_pixel(8'd170, 8'd85, 8'd255, 8'd170, 1'b0);
        wait_drained();

        send_idle_pct  = 8;
        recv_stall_pct <= 81;
        repeat (250) offer_random_pixel();
        wait_drained();

        send_idle_pct  = 81;
        recv_stall_pct <= 8;
        repeat (250) offer_random_pixel();
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        hold_tickets   <= hold_tickets + 1;
        repeat (250) offer_random_pixel();
        wait_drained();

        repeat (12) @(posedge i_clk);
        $display("%0d pixels checked across idle mixes and a long output hold-off",
                 checked);
        $display("%0d wrapped, %0d transparent, %0d opaque", wrapped_count, white_count,
                 opaque_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/aup_pkg.sv
design/aup_div_stage.sv
design/argb_unpremultiply_pixel_top.sv
tb/unpremultiply_checker.sv
tb/tb_argb_unpremultiply_pixel_top.sv
